/* design/caip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package caip_pkg;

    localparam int IV_LEN_SHORT  = 8;
    localparam int IV_LEN_LONG   = 16;
    localparam int IV_LEN_RESET  = 8;
    localparam int COUNT_BYTES   = 2;
    localparam int ENTRY_BYTES   = 2 + 4;
    localparam int QUEUE_DEPTH_DEF = 3;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_IV    = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [15:0] number;
        logic [15:0] clear_len;
        logic [31:0] prot_len;
    } t_entry;

    typedef struct packed {
        logic [127:0] iv;
        logic [15:0]  total;
        logic [47:0]  sum;
        logic [1:0]   status;
    } t_summary;

    typedef struct packed {
        logic     has_entry;
        t_entry   entry;
        logic     has_summary;
        t_summary summary;
    } t_cmd;

endpackage

`default_nettype wire

/* design/cenc_aux_info_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Parses common-encryption sample auxiliary records one byte per transfer, at a sustained
// rate of one byte per clock cycle while the queue has room. The front end assembles
// the IV, the subsample count and each six-byte entry and hands finished results to a short
// queue; the back end drains one result per cycle into the output register unless the
// output stalls, so a byte that completes an entry and also ends the record yields an
// entry and a summary result, which the queue absorbs. The IV length register may only
// be written while no record bytes are in flight.
module cenc_aux_info_parser
    import caip_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_record,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [15:0]      o_entry_number,
    output logic [15:0]      o_clear_length,
    output logic [31:0]      o_protected_length,
    output logic [63:0]      o_iv_upper,
    output logic [63:0]      o_iv_lower,
    output logic [15:0]      o_entry_total,
    output logic [47:0]      o_byte_sum,
    output logic [1:0]       o_status,
    output logic             o_final_result
);

    logic q_push, q_wr_ready, q_pop, q_rd_valid;
    t_cmd q_wr_cmd, q_rd_cmd;

    caip_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_record (i_end_of_record),
        .i_q_ready       (q_wr_ready),
        .o_q_push        (q_push),
        .o_q_cmd         (q_wr_cmd)
    );

    caip_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (q_wr_cmd),
        .o_wr_ready (q_wr_ready),
        .i_pop      (q_pop),
        .o_rd_valid (q_rd_valid),
        .o_rd_cmd   (q_rd_cmd)
    );

    caip_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_rd_valid),
        .i_q_cmd            (q_rd_cmd),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_entry_number     (o_entry_number),
        .o_clear_length     (o_clear_length),
        .o_protected_length (o_protected_length),
        .o_iv_upper         (o_iv_upper),
        .o_iv_lower         (o_iv_lower),
        .o_entry_total      (o_entry_total),
        .o_byte_sum         (o_byte_sum),
        .o_status           (o_status),
        .o_final_result     (o_final_result)
    );

endmodule

`default_nettype wire

/* design/caip_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module caip_front
    import caip_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_record,
    input  wire logic       i_q_ready,
    output logic            o_q_push,
    output t_cmd            o_q_cmd
);

    typedef enum logic [4:0] {
        PH_IV    = 5'b00001,
        PH_COUNT = 5'b00010,
        PH_ENTRY = 5'b00100,
        PH_DONE  = 5'b01000,
        PH_BADIV = 5'b10000
    } t_phase;

    logic [7:0]   r_iv_len;
    t_phase       r_phase, n_phase;
    logic [4:0]   r_pos, n_pos;
    logic [127:0] r_iv, n_iv;
    logic [15:0]  r_count, n_count;
    logic [15:0]  r_done, n_done;
    logic [47:0]  r_asm, n_asm;
    logic [47:0]  r_sum, n_sum;
    logic         accept;
    t_cmd         cmd;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_iv    = r_iv;
        n_count = r_count;
        n_done  = r_done;
        n_asm   = r_asm;
        n_sum   = r_sum;
        cmd     = '0;
        if (accept) begin
            case (r_phase)
                PH_IV: begin
                    if (r_iv_len != 8'(IV_LEN_SHORT) && r_iv_len != 8'(IV_LEN_LONG)) begin
                        n_iv    = '0;
                        n_phase = PH_BADIV;
                    end else begin
                        if (!r_pos[4]) begin
                            for (int k = 0; k < 16; k++) begin
                                if (r_pos[3:0] == 4'(k)) begin
                                    n_iv[(15 - k) * 8 +: 8] = i_data_byte;
                                end
                            end
                        end
                        n_pos = r_pos + 5'd1;
                        if ({3'b000, n_pos} >= r_iv_len) begin
                            n_phase = PH_COUNT;
                            n_pos   = '0;
                            n_asm   = '0;
                        end
                    end
                end
                PH_COUNT: begin
                    n_asm = {32'b0, r_asm[7:0], i_data_byte};
                    n_pos = r_pos + 5'd1;
                    if (n_pos >= 5'(COUNT_BYTES)) begin
                        n_count = n_asm[15:0];
                        n_asm   = '0;
                        n_pos   = '0;
                        n_phase = (n_asm[15:0] == 16'd0 && r_asm[7:0] == 8'd0
                                   && i_data_byte == 8'd0) ? PH_DONE : PH_ENTRY;
                    end
                end
                PH_ENTRY: begin
                    n_asm = {r_asm[39:0], i_data_byte};
                    n_pos = r_pos + 5'd1;
                    if (n_pos >= 5'(ENTRY_BYTES)) begin
                        cmd.has_entry       = 1'b1;
                        cmd.entry.number    = r_done;
                        cmd.entry.clear_len = n_asm[47:32];
                        cmd.entry.prot_len  = n_asm[31:0];
                        n_sum  = r_sum + {32'b0, n_asm[47:32]} + {16'b0, n_asm[31:0]};
                        n_done = r_done + 16'd1;
                        n_asm  = '0;
                        n_pos  = '0;
                        if (n_done == r_count) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_end_of_record) begin
                cmd.has_summary = 1'b1;
                case (n_phase)
                    PH_BADIV: cmd.summary.status = ST_BAD_IV;
                    PH_IV:    cmd.summary.status = ST_TRUNCATED;
                    PH_ENTRY: cmd.summary.status = ST_TRUNCATED;
                    PH_COUNT: cmd.summary.status = (n_pos == 5'd0) ? ST_OK : ST_TRUNCATED;
                    default:  cmd.summary.status = ST_OK;
                endcase
                if (n_phase != PH_BADIV) begin
                    cmd.summary.iv    = n_iv;
                    cmd.summary.total = n_count;
                    cmd.summary.sum   = n_sum;
                end
                n_phase = PH_IV;
                n_pos   = '0;
                n_iv    = '0;
                n_count = '0;
                n_done  = '0;
                n_asm   = '0;
                n_sum   = '0;
            end
        end
    end

    assign o_q_push = accept && (cmd.has_entry || cmd.has_summary);
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_len <= 8'(IV_LEN_RESET);
        end else if (i_cfg_wr_en) begin
            r_iv_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IV;
            r_pos   <= '0;
            r_iv    <= '0;
            r_count <= '0;
            r_done  <= '0;
            r_asm   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_iv    <= n_iv;
            r_count <= n_count;
            r_done  <= n_done;
            r_asm   <= n_asm;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

/* design/caip_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module caip_queue
    import caip_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_wr_ready,
    input  wire logic i_pop,
    output logic      o_rd_valid,
    output t_cmd      o_rd_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_fill;
    logic          do_push, do_pop;

    assign o_wr_ready = (r_fill != CW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_fill != '0);
    assign o_rd_cmd   = r_slot[r_rd_ptr];
    assign do_push    = i_push && o_wr_ready;
    assign do_pop     = i_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* design/caip_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module caip_back
    import caip_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_cmd   i_q_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output logic        o_result_kind,
    output logic [15:0] o_entry_number,
    output logic [15:0] o_clear_length,
    output logic [31:0] o_protected_length,
    output logic [63:0] o_iv_upper,
    output logic [63:0] o_iv_lower,
    output logic [15:0] o_entry_total,
    output logic [47:0] o_byte_sum,
    output logic [1:0]  o_status,
    output logic        o_final_result
);

    logic        r_out_valid;
    logic        r_entry_sent;
    logic        r_kind;
    t_entry      r_entry;
    t_summary    r_summary;
    logic        r_final;
    logic        slot_free;
    logic        load;
    logic        emit_entry;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign load       = slot_free && i_q_valid;
    assign emit_entry = i_q_cmd.has_entry && !r_entry_sent;
    assign o_pop      = load && (!emit_entry || !i_q_cmd.has_summary);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_entry_sent <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid  <= 1'b1;
                r_entry_sent <= emit_entry && i_q_cmd.has_summary;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_entry) begin
                r_kind    <= KIND_ENTRY;
                r_entry   <= i_q_cmd.entry;
                r_summary <= '0;
                r_final   <= !i_q_cmd.has_summary;
            end else begin
                r_kind    <= KIND_SUMMARY;
                r_entry   <= '0;
                r_summary <= i_q_cmd.summary;
                r_final   <= 1'b1;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_entry_number     = r_entry.number;
    assign o_clear_length     = r_entry.clear_len;
    assign o_protected_length = r_entry.prot_len;
    assign o_iv_upper         = r_summary.iv[127:64];
    assign o_iv_lower         = r_summary.iv[63:0];
    assign o_entry_total      = r_summary.total;
    assign o_byte_sum         = r_summary.sum;
    assign o_status           = r_summary.status;
    assign o_final_result     = r_final;

endmodule

`default_nettype wire

/* design/caip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module caip_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_result_kind,
    input wire logic [15:0] o_entry_total,
    input wire logic [63:0] o_iv_upper,
    input wire logic [63:0] o_iv_lower,
    input wire logic [47:0] o_byte_sum,
    input wire logic [1:0]  o_status,
    input wire logic        o_final_result
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_status)
            && $stable(o_byte_sum))
        else $error("output transfer changed while stalled");

    a_summary_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_final_result)
        else $error("record summary not marked final");

    a_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |->
            o_status == 2'd0 && o_entry_total == 16'd0 && o_byte_sum == 48'd0)
        else $error("entry carries summary fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_bad_iv_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == 2'd1 |->
            o_iv_upper == 64'd0 && o_iv_lower == 64'd0 && o_byte_sum == 48'd0)
        else $error("bad IV summary carries data");

endmodule

bind cenc_aux_info_parser caip_checker u_caip_checker (.*);

`default_nettype wire
